// File: design/cva_pkg.sv
// Shared types, constants and helper functions for the column vertical advection block.
// No dependencies; every other design file but cva_chk imports this package.
`default_nettype none
package cva_pkg;

  localparam int MAX_LAYERS = 32;
  localparam int CNT_W      = $clog2(MAX_LAYERS + 1);
  localparam int IDX_W      = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int OUT_IDX_W  = 5;
  localparam int SUM_W      = (CNT_W + 1 > OUT_IDX_W) ? CNT_W + 1 : OUT_IDX_W;

  localparam int COURANT_LIM = 16777216;
  localparam int HALF_Q      = 32768;

  // divider shape
  localparam int DIV_N_W   = 64;
  localparam int DIV_D_W   = 47;
  localparam int DIV_Q_W   = 33;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

  // configuration register indexes
  localparam logic REG_TIME_STEP    = 1'b0;
  localparam logic REG_COLUMN_DEPTH = 1'b1;

  typedef struct packed {
    logic signed [31:0] tracer;
    logic signed [31:0] vel;
    logic        [30:0] thick;
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic               cflag;
  } layer_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_F_MUL,
    ST_F_DIV,
    ST_F_COEF,
    ST_F_LEFT,
    ST_F_RIGHT,
    ST_X_T,
    ST_X_CDIV,
    ST_X_FLUX,
    ST_X_DLO,
    ST_X_DHI,
    ST_OUT
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    else if (v < -50'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // divide by 65536, rounding toward zero
  function automatic logic signed [47:0] trunc16(input logic signed [63:0] x);
    logic signed [63:0] b;
    b = x + (x[63] ? 64'sd65535 : 64'sd0);
    return b[63:16];
  endfunction

endpackage
`default_nettype wire

// File: design/cva_cell.sv
// One cell of the layer ring: holds one layer record, loads its input on shift.
// Depends on cva_pkg for the layer record type.
`default_nettype none
module cva_cell (
  input  wire logic            clk_i,
  input  wire logic            shift_i,
  input  wire cva_pkg::layer_t d_i,
  output cva_pkg::layer_t      q_o
);
  import cva_pkg::*;

  layer_t layer_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      layer_q <= d_i;
    end
  end

  assign q_o = layer_q;

endmodule
`default_nettype wire

// File: design/cva_chain.sv
// Ring of layer cells: each shift moves every cell one place toward the head.
// Depends on cva_pkg and cva_cell.
`default_nettype none
module cva_chain (
  input  wire logic            clk_i,
  input  wire logic            shift_i,
  input  wire cva_pkg::layer_t top_i,
  input  wire cva_pkg::layer_t next_i,
  output cva_pkg::layer_t      head_o,
  output cva_pkg::layer_t      next_o,
  output cva_pkg::layer_t      prev_o
);
  import cva_pkg::*;

  localparam int NEXT_POS = (MAX_LAYERS > 1) ? 1 : 0;

  layer_t cell_q [MAX_LAYERS];

  for (genvar k = 0; k < MAX_LAYERS; k++) begin : g_cell
    layer_t d;
    if (k == MAX_LAYERS - 1) begin : g_top
      assign d = top_i;
    end else if (k == 0) begin : g_head
      assign d = next_i;
    end else begin : g_mid
      assign d = cell_q[k + 1];
    end
    cva_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift_i),
      .d_i    (d),
      .q_o    (cell_q[k])
    );
  end

  assign head_o = cell_q[0];
  assign next_o = cell_q[NEXT_POS];
  assign prev_o = cell_q[MAX_LAYERS - 1];

endmodule
`default_nettype wire

// File: design/cva_div.sv
// Restoring divider, one quotient bit per cycle, 33-bit quotient plus overflow flag.
// Depends on cva_pkg for widths and the status struct.
`default_nettype none
module cva_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [cva_pkg::DIV_N_W-1:0]  num_i,
  input  wire logic [cva_pkg::DIV_D_W-1:0]  den_i,
  output cva_pkg::div_stat_t                stat_o,
  output logic      [cva_pkg::DIV_Q_W-1:0]  quo_o
);
  import cva_pkg::*;

  localparam int HI_W = DIV_N_W - DIV_Q_W;

  logic                 busy_q;
  logic                 done_q;
  logic                 ovf_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_D_W-1:0]   rem_q;
  logic [DIV_Q_W-1:0]   qn_q;
  logic [DIV_D_W:0]     trial;
  logic                 ge;

  assign trial = {rem_q, qn_q[DIV_Q_W-1]};
  assign ge    = trial >= {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_Q_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DIV_D_W'(num_i[DIV_N_W-1:DIV_Q_W]);
      qn_q  <= num_i[DIV_Q_W-1:0];
      ovf_q <= DIV_D_W'(num_i[DIV_N_W-1:DIV_Q_W]) >= den_i ||
               (HI_W > DIV_D_W);
    end else if (busy_q) begin
      rem_q <= ge ? DIV_D_W'(trial - {1'b0, den_i}) : trial[DIV_D_W-1:0];
      qn_q  <= {qn_q[DIV_Q_W-2:0], ge};
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;
  assign quo_o       = qn_q;

endmodule
`default_nettype wire

// File: design/column_vertical_advection.sv
// Column vertical advection: one upwind, slope-limited finite-volume step per column.
// Sequence: layers load one per cycle; after the last layer the block runs three ring
// passes of MAX_LAYERS steps each: faces (one divider run per layer), fluxes (three divider
// runs per inner interface with nonzero velocity), then one result per cycle while the
// output is not stalled. Throughput is set by the shared bit-serial divider. Reset clears
// the FSM, the layer count and config registers (time_step 0, column_depth 1.0), not cells.
`default_nettype none
module column_vertical_advection (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,  // tracer_value, vertical_velocity, layer_thickness
  input  wire logic        s_axis_tlast,  // last_layer
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // updated_value, layer_index
  output logic             m_axis_tuser,  // courant_exceeded
  output logic             m_axis_tlast,  // last_result
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [30:0] cfg_data_i
);
  import cva_pkg::*;

  // ---------------------------------------------------------------- control state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q;       // layers loaded, then column size during passes
  logic [IDX_W-1:0]  r_q;         // ring step within the current pass
  logic              go_q;        // divider start pulse
  logic [30:0]       dt_q;
  logic [30:0]       h_q;

  // ---------------------------------------------------------------- datapath regs
  logic [46:0]        num_q, den_q;
  logic               csign_q;
  logic signed [32:0] g_q;
  logic [24:0]        umag_q;
  logic signed [26:0] cl_q, cr_q;
  logic               cflag_q;
  logic signed [31:0] al_q;
  logic signed [31:0] t_q;
  logic signed [31:0] c_q;
  logic signed [47:0] flux_q;
  logic signed [31:0] ai_q;

  // ---------------------------------------------------------------- ring
  layer_t head, nxt, prev, top_in, head_out, next_out, new_layer;
  logic   shift;

  cva_chain u_chain (
    .clk_i  (clk_i),
    .shift_i(shift),
    .top_i  (top_in),
    .next_i (next_out),
    .head_o (head),
    .next_o (nxt),
    .prev_o (prev)
  );

  // ---------------------------------------------------------------- divider
  logic [DIV_N_W-1:0] dv_num;
  logic [DIV_D_W-1:0] dv_den;
  logic [DIV_Q_W-1:0] dv_quo;
  div_stat_t          dv_stat;

  cva_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(go_q),
    .num_i  (dv_num),
    .den_i  (dv_den),
    .stat_o (dv_stat),
    .quo_o  (dv_quo)
  );

  // ---------------------------------------------------------------- ring position
  // Layer i sits at the head when r + n - MAX_LAYERS == i; the top layer is always
  // at the head on the final step of a pass.
  logic [SUM_W-1:0] rn, rn_off;
  logic             act, first, last_step, single, in_acc, w_zero, adv;

  assign rn        = SUM_W'(r_q) + SUM_W'(cnt_q);
  assign rn_off    = rn - SUM_W'(MAX_LAYERS);
  assign act       = rn >= SUM_W'(MAX_LAYERS);
  assign first     = rn == SUM_W'(MAX_LAYERS);
  assign last_step = r_q == IDX_W'(MAX_LAYERS - 1);
  assign single    = cnt_q == CNT_W'(1);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign w_zero    = head.vel == 32'sd0;
  assign adv       = !act || m_axis_tready;

  assign new_layer.tracer = s_axis_tdata[31:0];
  assign new_layer.vel    = s_axis_tdata[63:32];
  assign new_layer.thick  = s_axis_tdata[94:64];
  assign new_layer.left   = '0;
  assign new_layer.right  = '0;
  assign new_layer.cflag  = 1'b0;

  // ---------------------------------------------------------------- face pass math
  logic signed [32:0] wsum, g_d;
  logic        [32:0] wmag;
  logic        [63:0] p_num;
  logic        [61:0] p_den;
  logic signed [32:0] d_up, d_dn, d_c;
  logic        [24:0] umag_d;
  logic signed [26:0] u, clf, crf, clh, crh;
  logic signed [26:0] coef;
  logic signed [59:0] p_face;
  logic signed [47:0] face_tr;
  logic signed [31:0] face_val;

  always_comb begin
    wsum  = 33'(head.vel) + (first ? 33'sd0 : 33'(prev.vel));
    wmag  = wsum[32] ? 33'(-wsum) : 33'(wsum);
    p_num = 64'(dt_q) * 64'(wmag);
    p_den = 62'(head.thick) * 62'(h_q);
    d_up  = 33'(nxt.tracer) - 33'(head.tracer);
    d_dn  = 33'(head.tracer) - 33'(prev.tracer);
    d_c   = 33'(nxt.tracer) - 33'(prev.tracer);
    if (single)         g_d = '0;
    else if (first)     g_d = d_up;
    else if (last_step) g_d = d_dn;
    else                g_d = (d_c + (d_c[32] ? 33'sd1 : 33'sd0)) >>> 1;

    if (num_q == '0) umag_d = '0;
    else if (dv_stat.ovf || dv_quo > DIV_Q_W'(COURANT_LIM)) umag_d = 25'(COURANT_LIM);
    else umag_d = dv_quo[24:0];

    u   = csign_q ? -$signed({2'b0, umag_q}) : $signed({2'b0, umag_q});
    clf = 27'sd65536 - u;
    crf = -27'sd65536 - u;
    clh = (clf + (clf[26] ? 27'sd1 : 27'sd0)) >>> 1;
    crh = (crf + (crf[26] ? 27'sd1 : 27'sd0)) >>> 1;

    // one multiplier serves both faces
    coef     = (state_q == ST_F_LEFT) ? cl_q : cr_q;
    p_face   = 60'(coef) * 60'(g_q);
    face_tr  = trunc16(64'(p_face));
    face_val = sat32(50'(head.tracer) + 50'(face_tr));
  end

  // ---------------------------------------------------------------- flux pass math
  logic signed [63:0] p_t, p_f;
  logic        [31:0] tmag;
  logic signed [31:0] c_d, face_sel;
  logic        [46:0] fmag;
  logic        [33:0] dmag;
  logic signed [34:0] delta;
  logic signed [31:0] a_lo, a_hi;
  logic        [30:0] hdiv, dz0, dz1;

  always_comb begin
    p_t  = $signed({1'b0, dt_q}) * head.vel;
    tmag = t_q[31] ? 32'(-t_q) : 32'(t_q);
    hdiv = (h_q == '0) ? 31'd1 : h_q;
    dz0  = (head.thick == '0) ? 31'd1 : head.thick;
    dz1  = (nxt.thick == '0) ? 31'd1 : nxt.thick;

    if (!t_q[31]) begin
      if (dv_stat.ovf || dv_quo > 33'd2147483647) c_d = 32'sh7fffffff;
      else c_d = dv_quo[31:0];
    end else begin
      if (dv_quo > 33'd2147483648 || dv_stat.ovf) c_d = 32'sh80000000;
      else c_d = 32'(-$signed({1'b0, dv_quo}));
    end

    face_sel = head.vel[31] ? nxt.right : head.left;
    p_f      = c_q * face_sel;
    fmag     = flux_q[47] ? 47'(-flux_q) : 47'(flux_q);
    dmag     = dv_stat.ovf ? 34'h200000000 : {1'b0, dv_quo};
    delta    = flux_q[47] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
    a_lo     = sat32(50'(head.tracer) - 50'(delta));
    a_hi     = sat32(50'(nxt.tracer) + 50'(delta));

    case (state_q)
      ST_F_DIV: begin
        dv_num = {1'b0, num_q, 16'b0};
        dv_den = den_q;
      end
      ST_X_CDIV: begin
        dv_num = {16'b0, tmag, 16'b0};
        dv_den = DIV_D_W'(hdiv);
      end
      ST_X_DLO: begin
        dv_num = {1'b0, fmag, 16'b0};
        dv_den = DIV_D_W'(dz0);
      end
      ST_X_DHI: begin
        dv_num = {1'b0, fmag, 16'b0};
        dv_den = DIV_D_W'(dz1);
      end
      default: begin
        dv_num = '0;
        dv_den = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:    if (in_acc && s_axis_tlast) state_d = ST_F_MUL;
      ST_F_MUL: begin
        if (!act) begin
          if (last_step) state_d = ST_X_T;
        end else begin
          state_d = ST_F_DIV;
        end
      end
      ST_F_DIV:   if (dv_stat.done) state_d = ST_F_COEF;
      ST_F_COEF:  state_d = ST_F_LEFT;
      ST_F_LEFT:  state_d = ST_F_RIGHT;
      ST_F_RIGHT: state_d = last_step ? ST_X_T : ST_F_MUL;
      ST_X_T: begin
        if (!act || last_step || w_zero) begin
          if (last_step) state_d = ST_OUT;
        end else begin
          state_d = ST_X_CDIV;
        end
      end
      ST_X_CDIV:  if (dv_stat.done) state_d = ST_X_FLUX;
      ST_X_FLUX:  state_d = ST_X_DLO;
      ST_X_DLO:   if (dv_stat.done) state_d = ST_X_DHI;
      ST_X_DHI:   if (dv_stat.done) state_d = ST_X_T;
      ST_OUT:     if (adv && last_step) state_d = ST_LOAD;
      default:    state_d = ST_LOAD;
    endcase
  end

  // ---------------------------------------------------------------- outputs / ring control
  always_comb begin
    shift         = 1'b0;
    head_out      = head;
    next_out      = nxt;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state_q)
      ST_LOAD: begin
        s_axis_tready = 1'b1;
        shift         = in_acc && (cnt_q < CNT_W'(MAX_LAYERS));
      end
      ST_F_MUL: shift = !act;
      ST_F_RIGHT: begin
        shift          = 1'b1;
        head_out.left  = al_q;
        head_out.right = face_val;
        head_out.cflag = cflag_q;
      end
      ST_X_T: shift = !act || last_step || w_zero;
      ST_X_DHI: begin
        shift           = dv_stat.done;
        head_out.tracer = ai_q;
        next_out.tracer = a_hi;
      end
      ST_OUT: begin
        m_axis_tvalid = act;
        shift         = adv;
      end
      default: shift = 1'b0;
    endcase
    top_in = (state_q == ST_LOAD) ? new_layer : head_out;
  end

  assign m_axis_tdata = {3'b0, rn_off[OUT_IDX_W-1:0], head.tracer};
  assign m_axis_tuser = head.cflag;
  assign m_axis_tlast = last_step;

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      r_q     <= '0;
      go_q    <= 1'b0;
      dt_q    <= '0;
      h_q     <= 31'd65536;
    end else begin
      state_q <= state_d;
      go_q    <= (state_d != state_q) &&
                 (state_d == ST_F_DIV || state_d == ST_X_CDIV ||
                  state_d == ST_X_DLO || state_d == ST_X_DHI);
      if (state_q == ST_LOAD) begin
        // count the layer, drop it once the ring is full
        if (in_acc && cnt_q < CNT_W'(MAX_LAYERS)) cnt_q <= cnt_q + 1'b1;
      end else if (shift) begin
        r_q <= last_step ? '0 : r_q + 1'b1;
        if (state_q == ST_OUT && last_step) cnt_q <= '0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TIME_STEP:    dt_q <= cfg_data_i;
          REG_COLUMN_DEPTH: h_q  <= cfg_data_i;
          default:          dt_q <= dt_q;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_F_MUL: begin
        num_q   <= p_num[62:16];
        den_q   <= p_den[61:15];
        csign_q <= wsum[32];
        g_q     <= g_d;
      end
      ST_F_DIV: if (dv_stat.done) umag_q <= umag_d;
      ST_F_COEF: begin
        cl_q    <= (clh > 27'sd32768) ? 27'sd32768 : clh;
        cr_q    <= (crh < -27'sd32768) ? -27'sd32768 : crh;
        cflag_q <= umag_q > 25'd65536;
      end
      ST_F_LEFT: al_q <= face_val;
      ST_X_T:    t_q  <= sat32(50'(trunc16(p_t)));
      ST_X_CDIV: if (dv_stat.done) c_q <= c_d;
      ST_X_FLUX: flux_q <= trunc16(p_f);
      ST_X_DLO:  if (dv_stat.done) ai_q <= a_lo;
      default:   ai_q <= ai_q;
    endcase
  end

endmodule
`default_nettype wire

// File: design/cva_chk.sv
// Port-level checks for column_vertical_advection, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module cva_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [95:0] s_axis_tdata,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast,
  input wire logic        cfg_we_i,
  input wire logic        cfg_idx_i,
  input wire logic [30:0] cfg_data_i
);

  // no input item is taken while results are being delivered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during result delivery");

  // the top-layer result closes the column
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
    else $error("result after last layer");

  // a closing input item starts processing, no immediate result
  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready && !m_axis_tvalid)
    else $error("column close not processed");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind column_vertical_advection cva_chk u_cva_chk (.*);
`default_nettype wire
